// ===== rtl/core/fbpp_pkg.sv =====
`default_nettype none

package fbpp_pkg;

    localparam logic [31:0] SYNC_WORD   = {8'hAA, 8'h99, 8'h55, 8'h66};
    localparam int unsigned REG_LIMIT   = 32;
    localparam logic [13:0] CMD_REG     = 14'd4;
    localparam logic [13:0] IDCODE_REG  = 14'd12;
    localparam logic [31:0] CMD_DESYNC  = 32'd13;
    localparam logic [27:0] TYPE2_EXTRA = 28'd2;

    localparam logic [2:0] PKT_TYPE1 = 3'd1;
    localparam logic [2:0] PKT_TYPE2 = 3'd2;

    localparam logic [1:0] OP_NOP   = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd2;

    typedef enum logic [1:0] {
        PH_SYNC    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_STOP    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_CMD   = 2'd1,
        KIND_ID    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_SYNC     = 3'd1,
        ST_BAD_REG     = 3'd2,
        ST_BAD_CMD_CNT = 3'd3,
        ST_BAD_ID_CNT  = 3'd4,
        ST_BAD_TYPE    = 3'd5
    } t_status;

    typedef struct packed {
        t_phase      phase;
        logic [27:0] words_left;
        t_kind       kind;
        logic        first_payload;
        t_status     error_code;
        logic        ended;
        logic [31:0] captured_id;
        logic        id_captured;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:         PH_SYNC,
        words_left:    28'd0,
        kind:          KIND_OTHER,
        first_payload: 1'b0,
        error_code:    ST_OK,
        ended:         1'b0,
        captured_id:   32'd0,
        id_captured:   1'b0
    };

endpackage

`default_nettype wire

// ===== rtl/core/fbpp_step.sv =====
`default_nettype none

module fbpp_step
    import fbpp_pkg::*;
(
    input  var t_state      i_state,
    input  wire  [31:0]     i_word,
    output t_state          o_state
);

    logic [2:0]  w_type;
    logic [1:0]  w_op;
    logic [13:0] w_reg;
    logic [10:0] w_cnt;
    logic [27:0] w_dec;
    logic        w_fail;

    assign w_type = i_word[31:29];
    assign w_op   = i_word[28:27];
    assign w_reg  = i_word[26:13];
    assign w_cnt  = i_word[10:0];
    assign w_dec  = (i_state.words_left != 28'd0) ? i_state.words_left - 28'd1 : 28'd0;

    always_comb begin
        o_state = i_state;
        w_fail  = 1'b0;
        case (i_state.phase)
            PH_SYNC: begin
                if (i_word == SYNC_WORD) begin
                    o_state.phase = PH_HEADER;
                end else begin
                    o_state.phase      = PH_STOP;
                    o_state.error_code = ST_NO_SYNC;
                end
            end
            PH_HEADER: begin
                if (w_type == PKT_TYPE1) begin
                    if (w_op != OP_NOP) begin
                        if ({1'b0, w_reg} >= 15'(REG_LIMIT)) begin
                            o_state.phase      = PH_STOP;
                            o_state.error_code = ST_BAD_REG;
                        end else begin
                            o_state.kind = KIND_OTHER;
                            if (w_op == OP_WRITE && w_reg == CMD_REG) begin
                                if (w_cnt != 11'd1) begin
                                    w_fail             = 1'b1;
                                    o_state.phase      = PH_STOP;
                                    o_state.error_code = ST_BAD_CMD_CNT;
                                end else begin
                                    o_state.kind = KIND_CMD;
                                end
                            end else if (w_op == OP_WRITE && w_reg == IDCODE_REG) begin
                                if (w_cnt != 11'd1) begin
                                    w_fail             = 1'b1;
                                    o_state.phase      = PH_STOP;
                                    o_state.error_code = ST_BAD_ID_CNT;
                                end else begin
                                    o_state.kind = KIND_ID;
                                end
                            end
                            // a zero count announces no payload
                            if (!w_fail && w_cnt != 11'd0) begin
                                o_state.words_left    = 28'(w_cnt);
                                o_state.first_payload = 1'b1;
                                o_state.phase         = PH_PAYLOAD;
                            end
                        end
                    end
                end else if (w_type == PKT_TYPE2) begin
                    o_state.kind          = KIND_OTHER;
                    o_state.first_payload = 1'b0;
                    o_state.words_left    = 28'({1'b0, i_word[26:0]}) + TYPE2_EXTRA;
                    o_state.phase         = PH_PAYLOAD;
                end else begin
                    o_state.phase      = PH_STOP;
                    o_state.error_code = ST_BAD_TYPE;
                end
            end
            PH_PAYLOAD: begin
                if (i_state.first_payload && i_state.kind == KIND_CMD
                        && i_word == CMD_DESYNC) begin
                    o_state.first_payload = 1'b0;
                    o_state.ended         = 1'b1;
                    o_state.phase         = PH_STOP;
                    o_state.words_left    = 28'd0;
                end else begin
                    o_state.first_payload = 1'b0;
                    if (i_state.first_payload && i_state.kind == KIND_ID) begin
                        o_state.captured_id = i_word;
                        o_state.id_captured = 1'b1;
                    end
                    o_state.words_left = w_dec;
                    if (w_dec == 28'd0) begin
                        o_state.phase = PH_HEADER;
                    end
                end
            end
            default: begin
                // stopped: ignore the word
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/fpga_bitstream_packet_parser_top.sv =====
// A result is registered and appears on the master side in the cycle after its word is accepted.
// Throughput: one word per cycle; the slave side stalls only while a result waits untaken.
// The parser state advances in one pass of header/payload decode per accepted word.
// Reset (synchronous, active low) returns the parser to expecting the sync word,
// clears the sticky error, DESYNC flag and captured ID code, and empties the output.
`default_nettype none

module fpga_bitstream_packet_parser_top
    import fbpp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // slave side: one bitstream word per request
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,   // [31:0] word
    input  wire         i_s_axis_tlast,   // last word of the bitstream
    // master side: one status result per accepted word
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // [2:0] status, [3] desync_seen,
                                          // [35:4] idcode_value, [36] idcode_valid,
                                          // [39:37] zero
);

    t_state      r_state;
    t_state      n_state;
    t_state      w_step;
    logic        r_m_valid;
    logic [39:0] r_m_data;
    logic        w_in_acc;

    // Accept a new request whenever the output register is empty or being drained.
    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    fbpp_step u_step (
        .i_state (r_state),
        .i_word  (i_s_axis_tdata),
        .o_state (w_step)
    );

    // The last word's result is formed from the advanced state, then the parser
    // drops back to its reset state ready for the next bitstream's sync word.
    always_comb begin
        n_state = r_state;
        if (w_in_acc) begin
            n_state = i_s_axis_tlast ? STATE_RESET : w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register: hold the result until the master side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_m_data <= {3'b000, w_step.id_captured, w_step.captured_id,
                         w_step.ended, w_step.error_code};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // A reported error or DESYNC mid-bitstream must leave the parser stopped.
    a_err_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_s_axis_tlast) |=>
            ((r_m_data[2:0] == ST_OK && !r_m_data[3]) || r_state.phase == PH_STOP))
        else $error("error or desync reported but parser not stopped");

    // Payload phase always has words still to consume.
    a_payload_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_PAYLOAD) |-> (r_state.words_left != 28'd0))
        else $error("payload phase with zero words left");

    // The ID code stays zero until one has been captured.
    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.id_captured |-> (r_state.captured_id == 32'd0))
        else $error("ID code set without capture");

    // The final word of a bitstream returns the parser to expecting sync.
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_axis_tlast) |=>
            (r_state.phase == PH_SYNC && r_state.error_code == ST_OK && !r_state.ended))
        else $error("parser not reset after last word");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import fbpp_pkg::*;

    // header codes the package leaves unnamed
    localparam logic [1:0]  OP_READ       = 2'd1;
    localparam logic [1:0]  OP_RESERVED   = 2'd3;
    localparam logic [2:0]  PKT_TYPE_TOP  = 3'd7;
    localparam logic [13:0] FIRST_BAD_REG = 14'(REG_LIMIT);
    localparam logic [13:0] LAST_GOOD_REG = 14'(REG_LIMIT - 1);

    localparam int ITEM_TARGET = 750;
    localparam int MAX_GAP     = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // [31:0] word
    logic        i_s_axis_tlast;   // last word of the bitstream
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;   // [2:0] status, [3] desync_seen, [35:4] idcode_value,
                                   // [36] idcode_valid, [39:37] zero

    fpga_bitstream_packet_parser_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Parser mirror: what the block should hold after each accepted word
    t_phase      ps_phase;
    logic [27:0] ps_remaining;
    t_kind       ps_dest;
    logic        ps_await_first;
    t_status     ps_err;
    logic        ps_stopped;
    logic [31:0] ps_id_word;
    logic        ps_id_seen;

    logic [39:0] pending_reports[$];   // predicted status results, oldest first
    logic [39:0] report_want;
    int          fail_count  = 0;
    int          items_sent  = 0;

    // idling controls shared between the test tasks and the two stream sides
    bit          tx_quiet    = 0;   // sender offers back to back
    bit          rx_quiet    = 0;   // receiver takes back to back
    int          rx_wait     = 0;   // stall drawn after each result
    int          rx_hold_len = 0;   // long hold-off requested by a test

    // bitstream framing for the random part
    int          stream_left;
    bit          stream_done;

    // ------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // end a hung run well after the slowest correct one would have finished
    initial begin
        #1_000_000;
        $display("** fpga_bitstream_packet_parser_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void reset_parser();
        ps_phase       = PH_SYNC;
        ps_remaining   = '0;
        ps_dest        = KIND_OTHER;
        ps_await_first = 1'b0;
        ps_err         = ST_OK;
        ps_stopped     = 1'b0;
        ps_id_word     = '0;
        ps_id_seen     = 1'b0;
    endfunction

    // Advance the mirror by one word and return the status result it yields.
    function automatic logic [39:0] next_report(input logic [31:0] w, input logic last);
        logic [2:0]  pkt;
        logic [1:0]  op;
        logic [13:0] addr;
        logic [10:0] cnt;
        t_status     fault;
        logic [39:0] report;
        pkt   = w[31:29];
        op    = w[28:27];
        addr  = w[26:13];
        cnt   = w[10:0];
        fault = ST_OK;
        case (ps_phase)
            PH_SYNC: begin
                if (w == SYNC_WORD) ps_phase = PH_HEADER;
                else fault = ST_NO_SYNC;
            end
            PH_HEADER: begin
                if (pkt == PKT_TYPE1) begin
                    // NOP: skip the header, its count means nothing
                    if (op != OP_NOP) begin
                        if (addr >= REG_LIMIT) begin
                            fault = ST_BAD_REG;
                        end else if (op == OP_WRITE && addr == CMD_REG && cnt != 11'd1) begin
                            fault = ST_BAD_CMD_CNT;
                        end else if (op == OP_WRITE && addr == IDCODE_REG && cnt != 11'd1) begin
                            fault = ST_BAD_ID_CNT;
                        end else begin
                            if (op == OP_WRITE && addr == CMD_REG) ps_dest = KIND_CMD;
                            else if (op == OP_WRITE && addr == IDCODE_REG) ps_dest = KIND_ID;
                            else ps_dest = KIND_OTHER;
                            // zero count: no payload follows
                            if (cnt != 11'd0) begin
                                ps_remaining   = {17'd0, cnt};
                                ps_await_first = 1'b1;
                                ps_phase       = PH_PAYLOAD;
                            end
                        end
                    end
                end else if (pkt == PKT_TYPE2) begin
                    ps_dest        = KIND_OTHER;
                    ps_await_first = 1'b0;
                    ps_remaining   = {1'b0, w[26:0]} + TYPE2_EXTRA;
                    ps_phase       = PH_PAYLOAD;
                end else begin
                    fault = ST_BAD_TYPE;
                end
            end
            PH_PAYLOAD: begin
                if (ps_await_first && ps_dest == KIND_CMD && w == CMD_DESYNC) begin
                    ps_await_first = 1'b0;
                    ps_stopped     = 1'b1;
                    ps_phase       = PH_STOP;
                    ps_remaining   = '0;
                end else begin
                    if (ps_await_first && ps_dest == KIND_ID) begin
                        ps_id_word = w;
                        ps_id_seen = 1'b1;
                    end
                    ps_await_first = 1'b0;
                    if (ps_remaining != 28'd0) ps_remaining = ps_remaining - 28'd1;
                    if (ps_remaining == 28'd0) ps_phase = PH_HEADER;
                end
            end
            default: ;
        endcase
        if (fault != ST_OK) begin
            ps_err   = fault;
            ps_phase = PH_STOP;
        end
        report = {3'b000, ps_id_seen, ps_id_word, ps_stopped, ps_err};
        // the last word reports first, then the parser starts over
        if (last) reset_parser();
        return report;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one request per call, gap drawn per word
    // ------------------------------------------------------------------
    task automatic send_word(input logic [31:0] w, input logic last);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = w;
        i_s_axis_tlast  = last;
        // hold the request until the block takes it
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_reports.push_back(next_report(w, last));
        items_sent++;
    endtask

    // Drop the request line and wait until every predicted result has come.
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] type1_header(input logic [1:0] op,
                                                 input logic [13:0] addr,
                                                 input logic [10:0] cnt);
        logic [1:0] spare;
        spare = 2'($urandom());
        return {PKT_TYPE1, op, addr, spare, cnt};
    endfunction

    // Send a word of the current bitstream; the word that uses up the budget carries tlast.
    task automatic put_word(input logic [31:0] w);
        if (!stream_done) begin
            stream_left--;
            send_word(w, stream_left == 0);
            stream_done = (stream_left == 0);
        end
    endtask

    // One packet with random content, mostly well formed.
    task automatic send_packet();
        int          pick;
        int          n;
        logic [1:0]  op;
        logic [13:0] addr;
        logic [10:0] cnt;
        logic [31:0] r;
        pick = $urandom_range(0, 99);
        r    = $urandom();
        if (pick < 8) begin
            put_word({PKT_TYPE1, OP_NOP, r[26:0]});
        end else if (pick < 30) begin
            // single-word command or ID-code write
            addr = $urandom_range(0, 1) ? CMD_REG : IDCODE_REG;
            put_word(type1_header(OP_WRITE, addr, 11'd1));
            put_word((addr == CMD_REG && $urandom_range(0, 2) == 0) ? CMD_DESYNC : r);
        end else if (pick < 60) begin
            op   = 2'($urandom_range(1, 3));
            addr = 14'($urandom_range(0, REG_LIMIT - 1));
            cnt  = 11'($urandom_range(0, 4));
            if (op == OP_WRITE && (addr == CMD_REG || addr == IDCODE_REG) &&
                $urandom_range(0, 3) != 0) cnt = 11'd1;
            put_word(type1_header(op, addr, cnt));
            for (n = 0; n < cnt; n++)
                put_word($urandom_range(0, 5) == 0 ? CMD_DESYNC : $urandom());
        end else if (pick < 80) begin
            // mostly short skips; now and then a huge one cut short by tlast
            if ($urandom_range(0, 29) != 0) r = $urandom_range(0, 5);
            put_word({PKT_TYPE2, r[28:0] & 29'h07FF_FFFF});
            for (n = 0; n < int'(r[26:0]) + 2 && !stream_done; n++) put_word($urandom());
        end else if (pick < 90) begin
            // any register, any count: bad addresses and counts show up here
            put_word({PKT_TYPE1, r[28:0]});
        end else begin
            put_word(r);
        end
    endtask

    task automatic run_stream(input int len);
        stream_left = len;
        stream_done = 0;
        // a tenth of the streams open with noise instead of the sync word
        if ($urandom_range(0, 9) == 0) put_word($urandom());
        else put_word(SYNC_WORD);
        while (!stream_done) begin
            // after a stop, cut the ignored tail short half of the time
            if (ps_phase == PH_STOP && $urandom_range(0, 1) == 0) stream_left = 1;
            send_packet();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall drawn per result, plus the long hold-off
    // ------------------------------------------------------------------
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                i_m_axis_tready = 1'b0;
                rx_hold_len--;
            end else if (rx_wait > 0) begin
                i_m_axis_tready = 1'b0;
                rx_wait--;
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare every taken result with the oldest prediction.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got %0h",
                             $time, o_m_axis_tdata);
                    fail_count++;
                end else begin
                    report_want = pending_reports.pop_front();
                    check_field("status", 32'(report_want[2:0]),
                                32'(o_m_axis_tdata[2:0]));
                    check_field("desync_seen", 32'(report_want[3]),
                                32'(o_m_axis_tdata[3]));
                    check_field("idcode_value", report_want[35:4], o_m_axis_tdata[35:4]);
                    check_field("idcode_valid", 32'(report_want[36]),
                                32'(o_m_axis_tdata[36]));
                    check_field("padding", 32'(report_want[39:37]),
                                32'(o_m_axis_tdata[39:37]));
                end
                rx_wait = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Anything but the sync word first is fatal; the next tlast clears it.
    task automatic test_sync_word();
        send_word(32'h0000_0000, 1'b0);
        send_word(SYNC_WORD, 1'b1);
        drain();
    endtask

    // Header forms that parse cleanly, with extreme fields.
    task automatic test_packet_kinds();
        send_word(SYNC_WORD, 1'b0);
        send_word({PKT_TYPE1, OP_NOP, 27'h7FF_FFFF}, 1'b0);
        send_word(type1_header(OP_WRITE, CMD_REG, 11'd1), 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(type1_header(OP_WRITE, IDCODE_REG, 11'd1), 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(type1_header(OP_READ, IDCODE_REG, 11'd2), 1'b0);
        send_word(32'h1234_5678, 1'b0);
        send_word(CMD_DESYNC, 1'b0);
        send_word(type1_header(OP_RESERVED, LAST_GOOD_REG, 11'd0), 1'b0);
        send_word({PKT_TYPE2, 29'd0}, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        drain();
    endtask

    // DESYNC on the command register stops parsing; later headers are ignored.
    task automatic test_desync();
        send_word(SYNC_WORD, 1'b0);
        send_word(type1_header(OP_WRITE, CMD_REG, 11'd1), 1'b0);
        send_word(CMD_DESYNC, 1'b0);
        send_word(type1_header(OP_WRITE, IDCODE_REG, 11'd7), 1'b1);
        drain();
    endtask

    // Each header fault, ended by the faulty header itself.
    task automatic test_header_faults();
        send_word(SYNC_WORD, 1'b0);
        send_word(type1_header(OP_READ, FIRST_BAD_REG, 11'd0), 1'b1);
        send_word(SYNC_WORD, 1'b0);
        send_word(type1_header(OP_WRITE, CMD_REG, 11'd0), 1'b1);
        send_word(SYNC_WORD, 1'b0);
        send_word(type1_header(OP_WRITE, IDCODE_REG, 11'h7FF), 1'b1);
        send_word(SYNC_WORD, 1'b0);
        send_word({PKT_TYPE_TOP, 29'h1FFF_FFFF}, 1'b1);
        drain();
    endtask

    // Hold the output off while words keep coming, so the input stalls.
    task automatic test_backpressure();
        rx_hold_len = 80;
        tx_quiet    = 1;
        run_stream(40);
        tx_quiet    = 0;
        drain();
    endtask

    task automatic test_random_streams();
        while (items_sent < ITEM_TARGET) begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            run_stream(($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40));
            // pause the sender now and then until the output has caught up
            if ($urandom_range(0, 9) == 0) drain();
        end
        tx_quiet = 0;
        rx_quiet = 0;
        drain();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        reset_parser();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_sync_word();
        test_packet_kinds();
        test_desync();
        test_header_faults();
        test_backpressure();
        test_random_streams();

        // leave room for any stray result
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending_reports.size() == 0) begin
            $display("** fpga_bitstream_packet_parser_top: PASSED **");
        end else begin
            $display("** fpga_bitstream_packet_parser_top: FAILED **");
        end
        $finish;
    end

endmodule
